### hdl/scfp_pkg.sv
`timescale 1ns / 1ps

package scfp_pkg;

	localparam int RAD_BITS    = 32;
	localparam int ROOT_BITS   = RAD_BITS / 2;
	localparam int M_BITS      = ROOT_BITS + 1;
	localparam int D_BITS      = ROOT_BITS + 2;
	localparam int PERIOD_BITS = 20;
	localparam int SQRT_STEPS  = RAD_BITS / 2;
	localparam int DIV_STEPS   = RAD_BITS;
	localparam int K_BITS      = $clog2(SQRT_STEPS);
	localparam int DCNT_BITS   = $clog2(DIV_STEPS);

	localparam logic [PERIOD_BITS-1:0] MAX_PERIOD = {PERIOD_BITS{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_MUL,
		ST_DIV_D,
		ST_WAIT_D,
		ST_DIV_M,
		ST_WAIT_M,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic                go;
		logic [RAD_BITS-1:0] dividend;
		logic [D_BITS-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [RAD_BITS-1:0] quotient;
		logic [D_BITS-1:0]   remainder;
	} div_rsp_t;

endpackage

### hdl/sqrt_continued_fraction_period.sv
`timescale 1ns / 1ps
// Period of the continued fraction of sqrt(radicand).
//
// Input: pulse start with radicand while busy is low; the item is taken at
// that edge and busy rises on the next cycle. Radicand is held internally.
// Output: done is high for exactly one cycle with period, is_square,
// odd_period and saturated valid in that cycle. The receiver cannot stall;
// a result that is not taken in its cycle is not signalled again.
// Sequence: the integer square root takes two radicand bits per cycle, and
// a perfect square returns done once it ends. Each period term then takes
// one multiply, two passes through the shared bit-serial divider, and one
// compare. The period count saturates at 2^20-1 terms. busy drops in the
// cycle done is shown, so the next item may be started then.
// Reset clears the sequencer, the divider and the done strobe; busy is low
// after reset.
module sqrt_continued_fraction_period import scfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [RAD_BITS-1:0]    radicand,
	output logic                   done,
	output logic [PERIOD_BITS-1:0] period,
	output logic                   is_square,
	output logic                   odd_period,
	output logic                   saturated
);

	state_t state_q, state_d;

	logic [RAD_BITS-1:0]    n_q;
	logic [RAD_BITS-1:0]    srem_q;
	logic [RAD_BITS-1:0]    res_q;
	logic [K_BITS-1:0]      k_q;
	logic [ROOT_BITS-1:0]   r_q;
	logic [M_BITS-1:0]      m_q;
	logic [D_BITS-1:0]      d_q;
	logic [RAD_BITS-1:0]    msq_q;
	logic [PERIOD_BITS-1:0] cnt_q;

	logic                   done_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic                   sq_q;
	logic                   odd_q;
	logic                   sat_q;

	logic [RAD_BITS-1:0]   sbit;
	logic [RAD_BITS:0]     ssum;
	logic                  sge;
	logic [RAD_BITS-1:0]   srem_next;
	logic [RAD_BITS-1:0]   res_next;
	logic                  sqrt_last;
	logic                  perfect;
	logic [2*M_BITS-1:0]   m_prod;
	logic [M_BITS-1:0]     rm_sum;
	logic [D_BITS-1:0]     m_next;
	logic                  closed;
	logic                  quo_zero;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic fin_square, fin_zero, fin_close, fin_sat;

	scfp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// square root: find one result bit per cycle
	assign sbit      = RAD_BITS'(1) << {k_q, 1'b0};
	assign ssum      = {1'b0, res_q} + {1'b0, sbit};
	assign sge       = {1'b0, srem_q} >= ssum;
	assign srem_next = sge ? (srem_q - ssum[RAD_BITS-1:0]) : srem_q;
	assign res_next  = sge ? ((res_q >> 1) + sbit) : (res_q >> 1);
	assign sqrt_last = (k_q == '0);
	assign perfect   = (srem_next == '0);

	assign m_prod   = m_q * m_q;
	assign rm_sum   = {1'b0, r_q} + m_q;
	assign m_next   = {2'b00, r_q} - div_rsp.remainder;
	assign closed   = ({1'b0, r_q} == m_q) && (d_q == D_BITS'(1));
	assign quo_zero = (div_rsp.quotient == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_SQRT;
			ST_SQRT:   if (sqrt_last) state_d = perfect ? ST_IDLE : ST_MUL;
			ST_MUL:    state_d = ST_DIV_D;
			ST_DIV_D:  state_d = ST_WAIT_D;
			ST_WAIT_D: if (div_rsp.done) state_d = quo_zero ? ST_IDLE : ST_DIV_M;
			ST_DIV_M:  state_d = ST_WAIT_M;
			ST_WAIT_M: if (div_rsp.done) state_d = ST_CHECK;
			ST_CHECK:  state_d = (closed || cnt_q == MAX_PERIOD) ? ST_IDLE : ST_MUL;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_req.go       = 1'b0;
		div_req.dividend = n_q - msq_q;
		div_req.divisor  = d_q;
		fin_square       = 1'b0;
		fin_zero         = 1'b0;
		fin_close        = 1'b0;
		fin_sat          = 1'b0;
		case (state_q)
			ST_SQRT:   fin_square = sqrt_last && perfect;
			ST_DIV_D:  div_req.go = 1'b1;
			ST_WAIT_D: fin_zero = div_rsp.done && quo_zero;
			ST_DIV_M: begin
				div_req.go       = 1'b1;
				div_req.dividend = RAD_BITS'(rm_sum);
			end
			ST_CHECK: begin
				fin_close = closed;
				fin_sat   = !closed && (cnt_q == MAX_PERIOD);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			srem_q   <= '0;
			res_q    <= '0;
			k_q      <= '0;
			r_q      <= '0;
			m_q      <= '0;
			d_q      <= D_BITS'(1);
			msq_q    <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			period_q <= '0;
			sq_q     <= 1'b0;
			odd_q    <= 1'b0;
			sat_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin_square || fin_zero || fin_close || fin_sat;
			case (state_q)
				ST_IDLE: if (start) begin
					n_q    <= radicand;
					srem_q <= radicand;
					res_q  <= '0;
					k_q    <= K_BITS'(SQRT_STEPS - 1);
				end
				ST_SQRT: begin
					srem_q <= srem_next;
					res_q  <= res_next;
					k_q    <= k_q - 1'b1;
					if (sqrt_last) begin
						r_q   <= res_next[ROOT_BITS-1:0];
						m_q   <= {1'b0, res_next[ROOT_BITS-1:0]};
						d_q   <= D_BITS'(1);
						cnt_q <= '0;
					end
				end
				ST_MUL: msq_q <= m_prod[RAD_BITS-1:0];
				ST_WAIT_D: if (div_rsp.done && !quo_zero) d_q <= div_rsp.quotient[D_BITS-1:0];
				ST_WAIT_M: if (div_rsp.done) begin
					m_q   <= m_next[M_BITS-1:0];
					cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
			// hold the last result until the next one replaces it
			if (fin_square) begin
				period_q <= '0;
				sq_q     <= 1'b1;
				odd_q    <= 1'b0;
				sat_q    <= 1'b0;
			end else if (fin_zero || fin_sat) begin
				period_q <= MAX_PERIOD;
				sq_q     <= 1'b0;
				odd_q    <= 1'b0;
				sat_q    <= 1'b1;
			end else if (fin_close) begin
				period_q <= cnt_q;
				sq_q     <= 1'b0;
				odd_q    <= cnt_q[0];
				sat_q    <= 1'b0;
			end
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign period     = period_q;
	assign is_square  = sq_q;
	assign odd_period = odd_q;
	assign saturated  = sat_q;

endmodule

### hdl/scfp_div.sv
`timescale 1ns / 1ps

module scfp_div import scfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 run_q;
	logic                 done_q;
	logic [DCNT_BITS-1:0] cnt_q;
	logic [RAD_BITS-1:0]  quo_q;
	logic [D_BITS-1:0]    pr_q;
	logic [D_BITS-1:0]    dvs_q;

	logic [D_BITS:0] pr_shift;
	logic            ge;
	logic [D_BITS:0] pr_sub;

	// restoring step: one quotient bit per cycle
	assign pr_shift = {pr_q, quo_q[RAD_BITS-1]};
	assign ge       = pr_shift >= {1'b0, dvs_q};
	assign pr_sub   = pr_shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			pr_q   <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= run_q && !req.go && (cnt_q == '0);
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= DCNT_BITS'(DIV_STEPS - 1);
				quo_q <= req.dividend;
				pr_q  <= '0;
				dvs_q <= req.divisor;
			end else if (run_q) begin
				quo_q <= {quo_q[RAD_BITS-2:0], ge};
				pr_q  <= ge ? pr_sub[D_BITS-1:0] : pr_shift[D_BITS-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = pr_q;

endmodule

### hdl/scfp_chk.sv
`timescale 1ns / 1ps

module scfp_chk import scfp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic [RAD_BITS-1:0]    radicand,
	input logic                   done,
	input logic [PERIOD_BITS-1:0] period,
	input logic                   is_square,
	input logic                   odd_period,
	input logic                   saturated
);

	logic unused_rad;
	assign unused_rad = ^radicand;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_square: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_square |-> period == '0 && !odd_period && !saturated)
		else $error("perfect square result not clean");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> period == MAX_PERIOD && !odd_period && !is_square)
		else $error("saturated result inconsistent");

	a_odd: assert property (@(posedge clk) disable iff (!arst_n)
		done && !saturated |-> odd_period == period[0])
		else $error("odd flag does not match period");

endmodule

bind sqrt_continued_fraction_period scfp_chk u_scfp_chk (.*);

### tb/cf_period_checker.sv
`timescale 1ns / 1ps

module cf_period_checker import scfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic [RAD_BITS-1:0]    radicand,
	input  logic                   done,
	input  logic [PERIOD_BITS-1:0] period,
	input  logic                   is_square,
	input  logic                   odd_period,
	input  logic                   saturated,
	output int                     fail_count,
	output int                     pending
);

	typedef struct packed {
		logic [PERIOD_BITS-1:0] period;
		logic                   is_square;
		logic                   odd_period;
		logic                   saturated;
	} cf_result_t;

	cf_result_t expected_periods[$];
	int         errs = 0;

	// Period of the continued fraction of sqrt(n) through the (m, d) recurrence.
	function automatic cf_result_t expand_sqrt(logic [RAD_BITS-1:0] n_in);
		longint unsigned n, rem, root, probe, m, d, steps;
		bit              hit_limit;
		cf_result_t      r;
		n     = 64'(n_in);
		rem   = n;
		root  = 0;
		probe = 64'd1 << 62;
		r     = '0;
		while (probe > rem)
			probe >>= 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem  -= root + probe;
				root  = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		if (root * root == n) begin
			r.is_square = 1'b1;
			return r;
		end
		m         = root;
		d         = 1;
		steps     = 0;
		hit_limit = 1'b0;
		// the expansion is purely periodic: stop when (root, 1) comes back
		forever begin
			d = (n - m * m) / d;
			if (d == 0) begin
				hit_limit = 1'b1;
				break;
			end
			m = ((root + m) / d) * d - m;
			steps++;
			if (m == root && d == 1)
				break;
			if (steps >= MAX_PERIOD) begin
				hit_limit = 1'b1;
				break;
			end
		end
		if (hit_limit) begin
			r.period    = MAX_PERIOD;
			r.saturated = 1'b1;
		end else begin
			r.period     = steps[PERIOD_BITS-1:0];
			r.odd_period = steps[0];
		end
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk) begin : watch
		cf_result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_periods.size() == 0) begin
					$error("result with no item outstanding: period %0d", period);
					errs++;
				end else begin
					want = expected_periods.pop_front();
					compare_field("period", 32'(want.period), 32'(period));
					compare_field("is_square", 32'(want.is_square), 32'(is_square));
					compare_field("odd_period", 32'(want.odd_period), 32'(odd_period));
					compare_field("saturated", 32'(want.saturated), 32'(saturated));
				end
			end
			if (start && !busy)
				expected_periods.push_back(expand_sqrt(radicand));
		end
		fail_count <= errs;
		pending    <= expected_periods.size();
	end

endmodule

### tb/tb_sqrt_continued_fraction_period.sv
`timescale 1ns / 1ps

module tb_sqrt_continued_fraction_period;
	import scfp_pkg::*;

	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 83;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 10_000_000;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [RAD_BITS-1:0]    radicand;
	logic                   done;
	logic [PERIOD_BITS-1:0] period;
	logic                   is_square;
	logic                   odd_period;
	logic                   saturated;
	int                     fail_count;
	int                     pending;
	int                     cycle_count = 0;

	// squares, short periods near both ends of the range, odd periods
	logic [RAD_BITS-1:0] corner_radicands [17] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd13, 32'd61, 32'd139, 32'd991,
		32'h3FFF_FFFF, 32'h4000_0000, 32'h4000_0001, 32'hFFFE_0001, 32'hFFFE_0002,
		32'hFFFF_0000, 32'hFFFF_FFFF
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sqrt_continued_fraction_period uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.radicand  (radicand),
		.done      (done),
		.period    (period),
		.is_square (is_square),
		.odd_period(odd_period),
		.saturated (saturated)
	);

	cf_period_checker checker_inst (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.radicand  (radicand),
		.done      (done),
		.period    (period),
		.is_square (is_square),
		.odd_period(odd_period),
		.saturated (saturated),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sqrt_continued_fraction_period regression: fail");
			$finish;
		end
	end

	// Offer one radicand and hold it until the block takes the item.
	task automatic issue_radicand(logic [RAD_BITS-1:0] n, bit allow_gap);
		int gap;
		@(negedge clk);
		if (allow_gap && $urandom_range(0, 99) < 13) begin
			start = 1'b0;
			gap = $urandom_range(1, 40);
			repeat (gap) begin
				radicand = $urandom;
				@(negedge clk);
			end
		end
		start    = 1'b1;
		radicand = n;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Squares k*k, and radicands k*k + d with d dividing 2k, which have periods of one or two.
	function automatic logic [RAD_BITS-1:0] short_period_radicand();
		longint unsigned k;
		longint unsigned n;
		k = 64'($urandom_range(1, 65535));
		case ($urandom_range(0, 4))
			0: n = k * k + 1;
			1: n = k * k + 2;
			2: n = k * k + k;
			3: n = k * k + 2 * k;
			default: n = k * k;
		endcase
		return n[RAD_BITS-1:0];
	endfunction

	initial begin : stimulus
		int                  sel;
		logic [RAD_BITS-1:0] n;
		arst_n   = 1'b0;
		start    = 1'b0;
		radicand = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (corner_radicands[i])
			issue_radicand(corner_radicands[i], 1'b1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55)
				n = short_period_radicand();
			else if (sel < 90)
				n = $urandom_range(0, 4095);
			else if (sel < 96)
				n = $urandom_range(0, 1 << 16);
			else
				n = $urandom_range(0, 1 << 20);
			// keep the middle stretch back to back
			issue_radicand(n, !(i >= 30 && i < 60));
		end

		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("sqrt_continued_fraction_period regression: pass");
		else
			$display("sqrt_continued_fraction_period regression: fail");
		$finish;
	end

endmodule
